### sv/ahpid_pkg.sv
// ahpid_pkg: widths, gains, register indexes and shared types for the
// angle and height pid controller. no dependencies.
`default_nettype none

package ahpid_pkg;

  // field widths
  localparam int DATA_W    = 32;
  localparam int YAW_W     = 20;
  localparam int THR_W     = 17;
  localparam int DT_W      = 17;
  localparam int CFG_IDX_W = 3;
  localparam int INTEG_W   = 48;
  localparam int ACC_W     = 64;

  // shared multiplier operand widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // serial divider
  localparam int DIV_Q_W   = 32;
  localparam int DIV_CNT_W = 6;
  localparam int DIV_N_W   = 33;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROLL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;

  // gains in q8.24, hover and limits in q16.16
  localparam logic signed [MUL_B_W-1:0] KP_GAIN = 21'sd503316;
  localparam logic signed [MUL_B_W-1:0] KI_GAIN = 21'sd13422;
  localparam logic signed [MUL_B_W-1:0] KD_GAIN = 21'sd671089;
  localparam logic signed [40:0]        HOVER_Q16 = 41'sd38666;
  localparam logic signed [YAW_W-1:0]   YAW_LIMIT = 20'sd288358;
  localparam logic [THR_W-1:0]          ONE_Q16   = 17'd65536;

  // divider status toward the sequencer
  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [DIV_Q_W-1:0] quot;
  } ahpid_div_t;

endpackage

`default_nettype wire

### sv/ahpid_if.sv
// ahpid channel interfaces: measurement input, command output and
// setpoint write port. depends on ahpid_pkg.
`default_nettype none

interface ahpid_in_if;
  import ahpid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] yaw_measured;
  logic signed [DATA_W-1:0] height_measured;
  logic [DT_W-1:0]          time_step;
  modport source(output valid, yaw_measured, height_measured, time_step, input ready);
  modport sink(input valid, yaw_measured, height_measured, time_step, output ready);
endinterface

interface ahpid_out_if;
  import ahpid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] roll_command;
  logic signed [DATA_W-1:0] pitch_command;
  logic signed [YAW_W-1:0]  yaw_rate_command;
  logic [THR_W-1:0]         throttle_command;
  logic                     throttle_clamped;
  modport source(output valid, roll_command, pitch_command, yaw_rate_command,
                 throttle_command, throttle_clamped, input ready);
  modport sink(input valid, roll_command, pitch_command, yaw_rate_command,
               throttle_command, throttle_clamped, output ready);
endinterface

interface ahpid_cfg_if;
  import ahpid_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/ahpid_mul.sv
// ahpid_mul: shared signed multiplier with a registered product.
// depends on ahpid_pkg.
`default_nettype none

module ahpid_mul (
  input  wire logic                                  clk,
  input  wire logic signed [ahpid_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [ahpid_pkg::MUL_B_W-1:0]  b,
  output logic signed [ahpid_pkg::MUL_P_W-1:0]       prod_r
);
  import ahpid_pkg::*;

  // one product per cycle; the product is registered and appears in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

`default_nettype wire

### sv/ahpid_div.sv
// ahpid_div: restoring divider, one quotient bit per cycle, for the
// derivative term (|diff| << 16) / dt. depends on ahpid_pkg.
`default_nettype none

module ahpid_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [ahpid_pkg::DIV_N_W-1:0]     num_mag,
  input  wire logic [ahpid_pkg::DT_W-1:0]        den,
  output ahpid_pkg::ahpid_div_t                  res
);
  import ahpid_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DT_W-1:0]      rem_r;
  logic [DIV_Q_W-1:0]   lo_r;
  logic [DIV_Q_W-1:0]   quot_r;
  logic                 ovf_r;
  logic [DT_W:0]        trial;
  logic [DT_W:0]        trial_sub;
  logic                 fits;

  // trial subtract of the next dividend bit
  assign trial     = {rem_r, lo_r[DIV_Q_W-1]};
  assign fits      = trial >= {1'b0, den};
  assign trial_sub = trial - {1'b0, den};

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_Q_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // remainder and quotient; quotient of 2^32 or more is flagged up front
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num_mag[DIV_N_W-1:16];
      lo_r   <= {num_mag[15:0], 16'h0000};
      quot_r <= '0;
      ovf_r  <= num_mag >= {den, 16'h0000};
    end else if (busy_r) begin
      rem_r  <= fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
      lo_r   <= {lo_r[DIV_Q_W-2:0], 1'b0};
      quot_r <= {quot_r[DIV_Q_W-2:0], fits};
    end
  end

  assign res.done = !busy_r;
  assign res.ovf  = ovf_r;
  assign res.quot = quot_r;

endmodule

`default_nettype wire

### sv/angle_height_pid_controller.sv
// angle_height_pid_controller: top level with setpoint registers, pid state
// and the sequencer over ahpid_mul and ahpid_div. depends on ahpid_pkg, ahpid_if.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   yaw_measured, height_measured, time_step
//   out_ch   out  valid/ready   roll, pitch, yaw_rate, throttle, throttle_clamped
//   cfg_ch   in   valid/ready   index, data (setpoint write)
//
// the time from acceptance to result is set by the 32-step serial divider of
// the derivative term, skipped with a zero derivative on the first tick after
// reset or a setpoint write, or for a zero time step. the next request is
// taken the cycle after the result is loaded.
// in_ch.ready is high only while the sequencer is idle; the result sits in an
// output register, so a stalled out_ch only holds the block at its last step.
// synchronous active-low reset clears setpoints, integral, last error and sets
// the first-tick flag; cfg_ch is always ready.
`default_nettype none

module angle_height_pid_controller (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ahpid_in_if.sink   in_ch,
  ahpid_out_if.source out_ch,
  ahpid_cfg_if.sink  cfg_ch
);
  import ahpid_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ERR    = 4'd1;
  localparam logic [3:0] S_PINC   = 4'd2;
  localparam logic [3:0] S_INTEG  = 4'd3;
  localparam logic [3:0] S_MI_LO  = 4'd4;
  localparam logic [3:0] S_MI_HI  = 4'd5;
  localparam logic [3:0] S_MI_HI2 = 4'd6;
  localparam logic [3:0] S_DWAIT  = 4'd7;
  localparam logic [3:0] S_MD     = 4'd8;
  localparam logic [3:0] S_MD_ACC = 4'd9;
  localparam logic [3:0] S_SUM    = 4'd10;
  localparam logic [3:0] S_AW     = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // setpoints and pid state
  logic signed [DATA_W-1:0]  sp_roll_r;
  logic signed [DATA_W-1:0]  sp_pitch_r;
  logic signed [DATA_W-1:0]  sp_yaw_r;
  logic signed [DATA_W-1:0]  sp_height_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [DATA_W-1:0]  prev_r;
  logic                      first_r;

  // working registers
  logic signed [DATA_W-1:0] yaw_in_r;
  logic signed [DATA_W-1:0] hgt_in_r;
  logic [DT_W-1:0]          dt_r;
  logic signed [DATA_W-1:0] err_r;
  logic signed [YAW_W-1:0]  yaw_rate_r;
  logic                     skip_r;
  logic                     dsign_r;
  logic signed [DATA_W-1:0] deriv_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [40:0]       desired_r;

  // output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_roll_r;
  logic signed [DATA_W-1:0] out_pitch_r;
  logic signed [YAW_W-1:0]  out_yaw_r;
  logic [THR_W-1:0]         out_thr_r;
  logic                     out_clamp_r;

  logic in_acc;
  logic cfg_acc;
  logic out_load;

  logic signed [DATA_W:0]    yaw_diff;
  logic signed [35:0]        yaw_ext;
  logic signed [35:0]        yaw_x6;
  logic signed [YAW_W-1:0]   yaw_sat;
  logic signed [DATA_W:0]    hgt_diff;
  logic signed [DATA_W-1:0]  err_sat;
  logic signed [DATA_W:0]    d_diff;
  logic [DIV_N_W-1:0]        d_mag;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [INTEG_W:0]   int_sum;
  logic signed [INTEG_W-1:0] int_sat;
  logic                      div_start;
  ahpid_div_t                div_res;
  logic                      q_big;
  logic signed [DATA_W-1:0]  deriv_sat;
  logic [THR_W-1:0]          thr;
  logic                      thr_clamp;
  logic signed [40:0]        excess;
  logic signed [INTEG_W+1:0] aw_sum;
  logic signed [INTEG_W-1:0] aw_sat;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // yaw proportional loop: 6 * error, clamped to the rate limit
  assign yaw_diff = {sp_yaw_r[DATA_W-1], sp_yaw_r} - {yaw_in_r[DATA_W-1], yaw_in_r};
  assign yaw_ext  = {{3{yaw_diff[DATA_W]}}, yaw_diff};
  assign yaw_x6   = (yaw_ext <<< 2) + (yaw_ext <<< 1);
  always_comb begin
    if (yaw_x6 > 36'sd288358) begin
      yaw_sat = YAW_LIMIT;
    end else if (yaw_x6 < -36'sd288358) begin
      yaw_sat = -YAW_LIMIT;
    end else begin
      yaw_sat = yaw_x6[YAW_W-1:0];
    end
  end

  // height error saturated to 32 bits
  assign hgt_diff = {sp_height_r[DATA_W-1], sp_height_r} - {hgt_in_r[DATA_W-1], hgt_in_r};
  always_comb begin
    if (hgt_diff[DATA_W] != hgt_diff[DATA_W-1]) begin
      err_sat = hgt_diff[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      err_sat = hgt_diff[DATA_W-1:0];
    end
  end

  // error difference for the derivative, as sign and magnitude
  assign d_diff = {err_r[DATA_W-1], err_r} - {prev_r[DATA_W-1], prev_r};
  assign d_mag  = d_diff[DATA_W] ? DIV_N_W'(-d_diff) : DIV_N_W'(d_diff);
  assign div_start = (state_r == S_PINC) && !skip_r;

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_PINC: begin
        mul_a = {err_r[DATA_W-1], err_r};
        mul_b = {{(MUL_B_W-DT_W){1'b0}}, dt_r};
      end
      S_INTEG: begin
        mul_a = {err_r[DATA_W-1], err_r};
        mul_b = KP_GAIN;
      end
      S_MI_LO: begin
        mul_a = {{(MUL_A_W-24){1'b0}}, integ_r[23:0]};
        mul_b = KI_GAIN;
      end
      S_MI_HI: begin
        mul_a = {{(MUL_A_W-24){integ_r[INTEG_W-1]}}, integ_r[INTEG_W-1:24]};
        mul_b = KI_GAIN;
      end
      S_MD: begin
        mul_a = {deriv_r[DATA_W-1], deriv_r};
        mul_b = KD_GAIN;
      end
      default: begin
        mul_a = {err_r[DATA_W-1], err_r};
        mul_b = '0;
      end
    endcase
  end

  ahpid_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  ahpid_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (d_mag),
    .den     (dt_r),
    .res     (div_res)
  );

  assign prod_ext = {{(ACC_W-MUL_P_W){prod_r[MUL_P_W-1]}}, prod_r};

  // integral increment, floor of (err * dt) >> 16, saturated to 48 bits
  assign int_sum = {integ_r[INTEG_W-1], integ_r}
                 + {{(INTEG_W+1-(MUL_P_W-16)){prod_r[MUL_P_W-1]}}, prod_r[MUL_P_W-1:16]};
  always_comb begin
    if (int_sum[INTEG_W] != int_sum[INTEG_W-1]) begin
      int_sat = int_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      int_sat = int_sum[INTEG_W-1:0];
    end
  end

  // derivative: signed quotient saturated to 32 bits
  assign q_big = div_res.ovf || div_res.quot[DIV_Q_W-1];
  always_comb begin
    if (dsign_r) begin
      deriv_sat = q_big ? {1'b1, {(DATA_W-1){1'b0}}} : -$signed(div_res.quot);
    end else begin
      deriv_sat = q_big ? {1'b0, {(DATA_W-1){1'b1}}} : $signed(div_res.quot);
    end
  end

  // throttle clamp to 0..1
  always_comb begin
    if (desired_r[40]) begin
      thr       = '0;
      thr_clamp = 1'b1;
    end else if (desired_r > 41'sd65536) begin
      thr       = ONE_Q16;
      thr_clamp = 1'b1;
    end else begin
      thr       = desired_r[THR_W-1:0];
      thr_clamp = 1'b0;
    end
  end

  // back-calculation: integral minus twice the clamp excess
  assign excess = desired_r - {{(41-THR_W){1'b0}}, thr};
  assign aw_sum = {{2{integ_r[INTEG_W-1]}}, integ_r} - {{8{excess[40]}}, excess, 1'b0};
  always_comb begin
    if (aw_sum[INTEG_W+1:INTEG_W-1] != 3'b000 && aw_sum[INTEG_W+1:INTEG_W-1] != 3'b111) begin
      aw_sat = aw_sum[INTEG_W+1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      aw_sat = aw_sum[INTEG_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_ERR;
      S_ERR:    state_nxt = S_PINC;
      S_PINC:   state_nxt = S_INTEG;
      S_INTEG:  state_nxt = S_MI_LO;
      S_MI_LO:  state_nxt = S_MI_HI;
      S_MI_HI:  state_nxt = S_MI_HI2;
      S_MI_HI2: state_nxt = S_DWAIT;
      S_DWAIT:  if (skip_r || div_res.done) state_nxt = S_MD;
      S_MD:     state_nxt = S_MD_ACC;
      S_MD_ACC: state_nxt = S_SUM;
      S_SUM:    state_nxt = S_AW;
      S_AW:     state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // setpoints and pid state; a write to indexes 0..3 restarts the height loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_roll_r   <= '0;
      sp_pitch_r  <= '0;
      sp_yaw_r    <= '0;
      sp_height_r <= '0;
      integ_r     <= '0;
      prev_r      <= '0;
      first_r     <= 1'b1;
    end else if (cfg_acc && cfg_ch.index <= REG_HEIGHT) begin
      case (cfg_ch.index)
        REG_ROLL:   sp_roll_r   <= cfg_ch.data;
        REG_PITCH:  sp_pitch_r  <= cfg_ch.data;
        REG_YAW:    sp_yaw_r    <= cfg_ch.data;
        REG_HEIGHT: sp_height_r <= cfg_ch.data;
        default:    sp_roll_r   <= sp_roll_r;
      endcase
      integ_r <= '0;
      prev_r  <= '0;
      first_r <= 1'b1;
    end else if (state_r == S_INTEG) begin
      integ_r <= int_sat;
    end else if (state_r == S_AW) begin
      integ_r <= aw_sat;
      prev_r  <= err_r;
      first_r <= 1'b0;
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      yaw_in_r <= in_ch.yaw_measured;
      hgt_in_r <= in_ch.height_measured;
      dt_r     <= in_ch.time_step;
    end
    case (state_r)
      S_ERR: begin
        err_r      <= err_sat;
        yaw_rate_r <= yaw_sat;
        skip_r     <= first_r || (dt_r == '0);
      end
      S_PINC:   dsign_r <= d_diff[DATA_W];
      S_MI_LO:  acc_r   <= prod_ext;
      S_MI_HI:  acc_r   <= acc_r + prod_ext;
      S_MI_HI2: acc_r   <= acc_r + (prod_ext <<< 24);
      S_DWAIT:  deriv_r <= skip_r ? '0 : deriv_sat;
      S_MD_ACC: acc_r   <= acc_r + prod_ext;
      S_SUM:    desired_r <= HOVER_Q16 + {acc_r[ACC_W-1], acc_r[ACC_W-1:24]};
      default:  acc_r   <= acc_r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_roll_r  <= sp_roll_r;
      out_pitch_r <= sp_pitch_r;
      out_yaw_r   <= yaw_rate_r;
      out_thr_r   <= thr;
      out_clamp_r <= thr_clamp;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.roll_command     = out_roll_r;
  assign out_ch.pitch_command    = out_pitch_r;
  assign out_ch.yaw_rate_command = out_yaw_r;
  assign out_ch.throttle_command = out_thr_r;
  assign out_ch.throttle_clamped = out_clamp_r;

`ifndef SYNTHESIS
  // throttle never leaves 0..1
  a_thr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_thr_r <= ONE_Q16)
    else $error("throttle above one");

  // an interior throttle is never flagged as clamped
  a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_thr_r != '0 && out_thr_r != ONE_Q16) |-> !out_clamp_r)
    else $error("clamp flag on unclamped throttle");

  // yaw rate stays within the limit
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_yaw_r <= YAW_LIMIT) && (out_yaw_r >= -YAW_LIMIT))
    else $error("yaw rate beyond limit");

  // divider is finished whenever the sequencer is idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> div_res.done)
    else $error("divider busy while idle");

  // an accepted request blocks the next one
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("ready right after request");
`endif

endmodule

`default_nettype wire

### tb/sv/angle_height_pid_controller_test.sv
// self-checking bench for angle_height_pid_controller: setpoint writes, measurement
// requests and command results checked against a cycle-free predictor of the pid.
// depends on ahpid_pkg, ahpid_if and the angle_height_pid_controller rtl.
`default_nettype none

module angle_height_pid_controller_test;
  import ahpid_pkg::*;

  localparam int    RANDOM_REQS = 1650;
  localparam int    CYCLE_LIMIT = 1_000_000;
  localparam int    DRAIN_WAIT  = 60;
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -S32_MAX - 1;
  localparam longint S48_MAX    = 64'sd140737488355327;
  localparam longint S48_MIN    = -S48_MAX - 1;
  localparam longint KP_Q24     = 503316;
  localparam longint KI_Q24     = 13422;
  localparam longint KD_Q24     = 671089;
  localparam longint HOVER      = 38666;
  localparam longint RATE_GAIN  = 6;
  localparam longint RATE_MAX   = 288358;
  localparam longint THR_FULL   = 65536;

  typedef struct packed {
    logic signed [DATA_W-1:0] yaw;
    logic signed [DATA_W-1:0] height;
    logic [DT_W-1:0]          dt_q16;
  } meas_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] roll;
    logic signed [DATA_W-1:0] pitch;
    logic signed [YAW_W-1:0]  yaw_rate;
    logic [THR_W-1:0]         throttle;
    logic                     clamped;
  } cmd_t;

  logic clk;
  logic rst_n;

  ahpid_in_if  in_ch();
  ahpid_out_if out_ch();
  ahpid_cfg_if cfg_ch();

  angle_height_pid_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted controller state
  longint setpoint [4];
  longint integ_acc;
  longint last_herr;
  bit     first_tick;

  meas_t  pending_reqs [$];
  cmd_t   cmd_expected [$];

  int     fail_count;
  int     n_reqs;
  int     n_writes;
  int     n_clamped;
  int     cycle_count;
  int     in_gap_max;
  int     out_gap_max;

  // handshake bookkeeping between posedge monitor and negedge drivers
  bit     in_taken;
  bit     out_taken;
  bit     in_busy;
  int     in_gap;
  int     out_wait;
  meas_t  next_req;
  meas_t  seen_req;
  cmd_t   want;

  function automatic longint clamp_range(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic logic [DATA_W-1:0] sat_word(input longint x);
    longint t;
    t = clamp_range(x, S32_MIN, S32_MAX);
    return t[DATA_W-1:0];
  endfunction

  // setpoint write: valid index stores the value and restarts the height pid
  function automatic void apply_setpoint_write(input logic [CFG_IDX_W-1:0] idx,
                                               input logic [DATA_W-1:0] data);
    if (idx <= REG_HEIGHT) begin
      setpoint[idx] = longint'(signed'(data));
      integ_acc     = 0;
      last_herr     = 0;
      first_tick    = 1'b1;
    end
  endfunction

  // one control tick: yaw p loop, height pid with back-calculation anti-windup
  function automatic cmd_t predict_commands(input meas_t m);
    cmd_t   c;
    longint dt;
    longint rate;
    longint herr;
    longint deriv;
    longint pid_sum;
    longint desired;
    longint thr;
    dt   = longint'(m.dt_q16);
    rate = clamp_range((setpoint[REG_YAW] - longint'(m.yaw)) * RATE_GAIN, -RATE_MAX, RATE_MAX);
    herr = clamp_range(setpoint[REG_HEIGHT] - longint'(m.height), S32_MIN, S32_MAX);
    integ_acc = clamp_range(integ_acc + ((herr * dt) >>> 16), S48_MIN, S48_MAX);
    if (first_tick || dt == 0) begin
      deriv = 0;
    end else begin
      deriv = clamp_range(((herr - last_herr) * 65536) / dt, S32_MIN, S32_MAX);
    end
    pid_sum = KP_Q24 * herr + KI_Q24 * integ_acc + KD_Q24 * deriv;
    desired = HOVER + (pid_sum >>> 24);
    thr     = clamp_range(desired, 0, THR_FULL);
    last_herr  = herr;
    integ_acc  = clamp_range(integ_acc - 2 * (desired - thr), S48_MIN, S48_MAX);
    first_tick = 1'b0;
    c.roll     = setpoint[REG_ROLL][DATA_W-1:0];
    c.pitch    = setpoint[REG_PITCH][DATA_W-1:0];
    c.yaw_rate = rate[YAW_W-1:0];
    c.throttle = thr[THR_W-1:0];
    c.clamped  = (desired != thr);
    return c;
  endfunction

  // clock
  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("angle_height_pid_controller_test: errors");
      $finish;
    end
  end

  // monitor: setpoint writes, accepted requests and command results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_setpoint_write(cfg_ch.index, cfg_ch.data);
        n_writes++;
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_req.yaw    = in_ch.yaw_measured;
        seen_req.height = in_ch.height_measured;
        seen_req.dt_q16 = in_ch.time_step;
        cmd_expected.push_back(predict_commands(seen_req));
        in_taken = 1'b1;
        n_reqs++;
      end
      if (out_ch.valid && out_ch.ready) begin
        out_taken = 1'b1;
        if (cmd_expected.size() == 0) begin
          $error("command result with no request outstanding");
          fail_count++;
        end else begin
          want = cmd_expected.pop_front();
          if (out_ch.roll_command !== want.roll) begin
            $error("roll_command expected %0d actual %0d", want.roll, out_ch.roll_command);
            fail_count++;
          end
          if (out_ch.pitch_command !== want.pitch) begin
            $error("pitch_command expected %0d actual %0d", want.pitch, out_ch.pitch_command);
            fail_count++;
          end
          if (out_ch.yaw_rate_command !== want.yaw_rate) begin
            $error("yaw_rate_command expected %0d actual %0d", want.yaw_rate,
                   out_ch.yaw_rate_command);
            fail_count++;
          end
          if (out_ch.throttle_command !== want.throttle) begin
            $error("throttle_command expected %0d actual %0d", want.throttle,
                   out_ch.throttle_command);
            fail_count++;
          end
          if (out_ch.throttle_clamped !== want.clamped) begin
            $error("throttle_clamped expected %0d actual %0d", want.clamped,
                   out_ch.throttle_clamped);
            fail_count++;
          end
          n_clamped += want.clamped;
        end
      end
    end
  end

  // request driver: one pending measurement at a time, random gap after each
  always @(negedge clk) begin
    if (in_taken) begin
      in_taken = 1'b0;
      in_busy  = 1'b0;
      in_gap   = $urandom_range(0, in_gap_max);
    end
    if (!in_busy) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        in_ch.yaw_measured    <= next_req.yaw;
        in_ch.height_measured <= next_req.height;
        in_ch.time_step       <= next_req.dt_q16;
        in_busy = 1'b1;
      end
    end
    in_ch.valid <= in_busy;
  end

  // result sink: random stall after each accepted result
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait  = $urandom_range(0, out_gap_max);
    end else if (out_wait > 0) begin
      out_wait--;
    end
    out_ch.ready <= (out_wait == 0);
  end

  task automatic write_setpoint(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic queue_req(input logic [DATA_W-1:0] yaw, input logic [DATA_W-1:0] height,
                           input logic [DT_W-1:0] dt);
    meas_t m;
    m.yaw    = yaw;
    m.height = height;
    m.dt_q16 = dt;
    pending_reqs.push_back(m);
  endtask

  // wait until every request went out and every result came back
  task automatic drain();
    while (pending_reqs.size() > 0 || in_busy || cmd_expected.size() > 0) @(negedge clk);
  endtask

  initial begin
    longint           ysp;
    longint           hsp;
    int               kind;
    int               k;
    int               n_rand;
    int               phase_len;
    int               n_cfg;
    logic [DATA_W-1:0]    yv;
    logic [DATA_W-1:0]    hv;
    logic [DATA_W-1:0]    val;
    logic [DT_W-1:0]      dv;
    logic [CFG_IDX_W-1:0] idx;

    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.yaw_measured = '0;
    in_ch.height_measured = '0;
    in_ch.time_step = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ROLL;
    cfg_ch.data = '0;
    for (int i = 0; i < 4; i++) setpoint[i] = 0;
    integ_acc = 0;
    last_herr = 0;
    first_tick = 1'b1;
    in_gap_max = 0;
    out_gap_max = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setpoints: first tick, zero step, field extremes, step above range
    queue_req(32'h0000_0000, 32'h0000_0000, 17'd65536);
    queue_req(32'h0000_0000, 32'h0000_0000, 17'd0);
    queue_req(32'h7fff_ffff, 32'h8000_0000, 17'd1);
    queue_req(32'h8000_0000, 32'h7fff_ffff, 17'd131071);
    queue_req(32'h0000_0000, 32'h0001_0000, 17'd65537);
    queue_req(32'h0000_8000, 32'hffff_0000, 17'd1);
    drain();

    // setpoint extremes one way
    write_setpoint(REG_ROLL,   32'h7fff_ffff);
    write_setpoint(REG_PITCH,  32'h8000_0000);
    write_setpoint(REG_YAW,    32'h7fff_ffff);
    write_setpoint(REG_HEIGHT, 32'h8000_0000);
    queue_req(32'h8000_0000, 32'h7fff_ffff, 17'd1);
    queue_req(32'h7fff_ffff, 32'h8000_0000, 17'd65536);
    drain();

    // and the other way, back to back with a full-width derivative step
    write_setpoint(REG_ROLL,   32'h8000_0000);
    write_setpoint(REG_PITCH,  32'h7fff_ffff);
    write_setpoint(REG_YAW,    32'h8000_0000);
    write_setpoint(REG_HEIGHT, 32'h7fff_ffff);
    queue_req(32'h7fff_ffff, 32'h8000_0000, 17'd2);
    queue_req(32'h0000_0000, 32'h7fff_ffff, 17'd1);
    drain();

    // modest setpoints: hover, small errors, unclamped throttle
    write_setpoint(REG_ROLL,   32'h0000_1234);
    write_setpoint(REG_PITCH,  32'hffff_bcdf);
    write_setpoint(REG_YAW,    32'h0001_0000);
    write_setpoint(REG_HEIGHT, 32'h000a_0000);
    queue_req(32'h0001_0000, 32'h000a_0000, 17'd655);
    queue_req(32'h0000_0000, 32'h0009_0000, 17'd655);
    queue_req(32'h0002_0000, 32'h000b_0000, 17'd655);
    drain();

    // out-of-range index is dropped and must not restart the pid
    write_setpoint(3'd4, 32'h0123_4567);
    write_setpoint(3'd7, 32'hfedc_ba98);
    queue_req(32'h0001_0000, 32'h0000_0000, 17'd1);
    queue_req(32'h0001_0000, 32'h0000_0000, 17'd6554);
    queue_req(32'h0001_0000, 32'h0014_0000, 17'd0);
    drain();

    // random phases: setpoint changes while idle, then bursts of ticks
    n_rand = 0;
    while (n_rand < RANDOM_REQS) begin
      drain();
      n_cfg = $urandom_range(0, 4);
      repeat (n_cfg) begin
        idx = ($urandom_range(0, 9) == 0) ? CFG_IDX_W'($urandom_range(4, 7))
                                          : CFG_IDX_W'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0: val = 32'h7fff_ffff;
          1: val = 32'h8000_0000;
          2: val = $urandom;
          default: val = int'($urandom) >>> $urandom_range(6, 12);
        endcase
        write_setpoint(idx, val);
      end
      case ($urandom_range(0, 3))
        0: begin in_gap_max = 0; out_gap_max = 0; end
        1: begin in_gap_max = 9; out_gap_max = 9; end
        2: begin in_gap_max = 9; out_gap_max = 0; end
        default: begin in_gap_max = 0; out_gap_max = 9; end
      endcase
      ysp = setpoint[REG_YAW];
      hsp = setpoint[REG_HEIGHT];
      phase_len = $urandom_range(20, 120);
      repeat (phase_len) begin
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
          // tracking near the setpoints with realistic steps
          k  = $urandom_range(8, 22);
          hv = sat_word(hsp + longint'(int'($urandom) >>> (31 - k)));
          yv = sat_word(ysp + longint'(int'($urandom) >>> $urandom_range(12, 28)));
          dv = ($urandom_range(0, 3) == 0) ? DT_W'($urandom_range(1, 65536))
                                           : DT_W'($urandom_range(1, 6554));
        end else if (kind < 85) begin
          yv = $urandom;
          hv = $urandom;
          dv = DT_W'($urandom_range(0, 131071));
        end else if (kind < 93) begin
          // step corners: zero, one, full second, above range
          yv = sat_word(ysp + longint'(int'($urandom) >>> 14));
          hv = sat_word(hsp + longint'(int'($urandom) >>> 10));
          case ($urandom_range(0, 3))
            0: dv = '0;
            1: dv = DT_W'(1);
            2: dv = DT_W'(65536);
            default: dv = DT_W'($urandom_range(65537, 131071));
          endcase
        end else begin
          // far from the setpoint: saturated error and throttle windup
          yv = ($urandom_range(0, 1) == 0) ? 32'h7fff_ffff : 32'h8000_0000;
          hv = ($urandom_range(0, 1) == 0) ? 32'h7fff_ffff : 32'h8000_0000;
          dv = DT_W'($urandom_range(1, 65536));
        end
        queue_req(yv, hv, dv);
        n_rand++;
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("run covered %0d measurement requests and %0d setpoint writes,", n_reqs, n_writes);
    $display("%0d results with the throttle clamped", n_clamped);
    if (fail_count == 0 && cmd_expected.size() == 0) begin
      $display("angle_height_pid_controller_test: clean");
    end else begin
      $display("angle_height_pid_controller_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
